// ===== src/ptwa_pkg.sv =====
package ptwa_pkg;

   localparam int POOL_FRAMES       = 16;
   localparam int ENTRIES_PER_TABLE = 512;

   localparam int IDX_W         = $clog2(ENTRIES_PER_TABLE);
   localparam int FRAME_W       = $clog2(POOL_FRAMES);
   localparam int NF_W          = $clog2(POOL_FRAMES + 1);
   localparam int TABLE_ENTRIES = POOL_FRAMES * ENTRIES_PER_TABLE;
   localparam int ADDR_W        = FRAME_W + IDX_W;

   localparam int PA_W       = 52;
   localparam int VA_W       = 48;
   localparam int PAGE_SHIFT = 12;
   localparam int PFN_W      = PA_W - PAGE_SHIFT;
   localparam int VPN_W      = VA_W - PAGE_SHIFT;
   localparam int PTE_SHIFT  = 3;
   localparam int MADE_W     = 2;

   // stored entry: present bit over the link frame number
   localparam int ENTRY_W = PFN_W + 1;

   // walk levels
   localparam logic [1:0] LVL_PML4 = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;

   typedef enum logic [2:0] {
      STEP_CLEAR,
      STEP_IDLE,
      STEP_READ,
      STEP_EVAL,
      STEP_EMIT
   } step_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_CLEAR_MORE,
      COND_NO_INPUT,
      COND_WALK_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     clear_wr;
      logic     take_in;
      logic     mem_rd;
      logic     eval;
      logic     emit;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } uword_type;

   typedef struct packed {
      logic clear_more;
      logic in_valid;
      logic walk_more;
      logic out_busy;
   } status_type;

   // control store: one word per step
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '{clear_wr: 1'b0, take_in: 1'b0, mem_rd: 1'b0, eval: 1'b0, emit: 1'b0,
            cond: COND_NEVER, on_true: STEP_IDLE, on_false: STEP_IDLE};
      unique case (step)
         STEP_CLEAR: begin
            w.clear_wr = 1'b1;
            w.cond     = COND_CLEAR_MORE;
            w.on_true  = STEP_CLEAR;
            w.on_false = STEP_IDLE;
         end
         STEP_IDLE: begin
            w.take_in  = 1'b1;
            w.cond     = COND_NO_INPUT;
            w.on_true  = STEP_IDLE;
            w.on_false = STEP_READ;
         end
         STEP_READ: begin
            w.mem_rd   = 1'b1;
            w.cond     = COND_NEVER;
            w.on_true  = STEP_EVAL;
            w.on_false = STEP_EVAL;
         end
         STEP_EVAL: begin
            w.eval     = 1'b1;
            w.cond     = COND_WALK_MORE;
            w.on_true  = STEP_READ;
            w.on_false = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit     = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.on_true  = STEP_EMIT;
            w.on_false = STEP_IDLE;
         end
         default: begin
            w.cond     = COND_NEVER;
            w.on_false = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== src/ptwa_req_if.sv =====
interface ptwa_req_if import ptwa_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [VA_W-1:0] vaddr;

   modport source (output valid, output vaddr, input ready);
   modport sink   (input valid, input vaddr, output ready);
endinterface

// ===== src/ptwa_rsp_if.sv =====
interface ptwa_rsp_if import ptwa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PA_W-1:0]   pte_address;
   logic              status;
   logic [MADE_W-1:0] tables_created;

   modport source (output valid, output pte_address, output status, output tables_created,
                   input ready);
   modport sink   (input valid, input pte_address, input status, input tables_created,
                   output ready);
endinterface

// ===== src/page_table_walk_allocate_core.sv =====
// Order: an item is accepted, then each level is read and evaluated on the single-port
// table memory (three levels; the walk stops early when a level fails), then the result
// is loaded; no new item is accepted until that load, which waits while the output is stalled.
// Reset: a clearing pass writes zero to all POOL_FRAMES*512 table entries, during which no
// item is accepted; pool_base resets to zero, the allocator to frame one.
module page_table_walk_allocate_core import ptwa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [PA_W-1:0] csr_wr_data,
   ptwa_req_if.sink        req_ch,
   ptwa_rsp_if.source      rsp_ch
);

   uword_type  ctrl;
   status_type stat;

   ptwa_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ptwa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctrl        (ctrl),
      .stat        (stat),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== src/ptwa_sequencer.sv =====
module ptwa_sequencer import ptwa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type stat,
   output uword_type  ctrl
);

   step_type  step_ff;
   step_type  step_in;
   uword_type uword;
   logic      cond_true;

   always_comb begin
      uword = ucode_rom(step_ff);
      unique case (uword.cond)
         COND_NEVER:      cond_true = 1'b0;
         COND_CLEAR_MORE: cond_true = stat.clear_more;
         COND_NO_INPUT:   cond_true = !stat.in_valid;
         COND_WALK_MORE:  cond_true = stat.walk_more;
         COND_OUT_BUSY:   cond_true = stat.out_busy;
         default:         cond_true = 1'b0;
      endcase
      step_in = cond_true ? uword.on_true : uword.on_false;
   end

   always_comb begin
      ctrl = uword;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== src/ptwa_datapath.sv =====
module ptwa_datapath import ptwa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [PA_W-1:0]   csr_wr_data,
   input  uword_type         ctrl,
   output status_type        stat,
   ptwa_req_if.sink          req_ch,
   ptwa_rsp_if.source        rsp_ch
);

   logic [PFN_W-1:0]   pool_base_ff;
   logic [VPN_W-1:0]   vpn_ff, vpn_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [1:0]         level_ff, level_in;
   logic [MADE_W-1:0]  made_ff, made_in;
   logic               fail_ff, fail_in;
   logic [NF_W-1:0]    next_free_ff, next_free_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   logic [ENTRY_W-1:0] table_mem [TABLE_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]    rsp_pte_ff;
   logic               rsp_status_ff;
   logic [MADE_W-1:0]  rsp_made_ff;

   logic [IDX_W-1:0]   walk_idx;
   logic [PFN_W-1:0]   link_off;
   logic [PFN_W-1:0]   alloc_pfn;
   logic [PFN_W-1:0]   leaf_pfn;
   logic               rd_present;
   logic               stale;
   logic               pool_full;
   logic               step_ok;
   logic               alloc_go;
   logic               accept;
   logic               out_busy;
   logic               out_load;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ENTRY_W-1:0] mem_wdata;

   always_comb begin
      unique case (level_ff)
         LVL_PML4: walk_idx = vpn_ff[VPN_W-1 -: IDX_W];
         LVL_PDPT: walk_idx = vpn_ff[VPN_W-1-IDX_W -: IDX_W];
         LVL_PD:   walk_idx = vpn_ff[VPN_W-1-2*IDX_W -: IDX_W];
         default:  walk_idx = vpn_ff[IDX_W-1:0];
      endcase
   end

   // link decode and allocation
   assign rd_present = rd_data_ff[ENTRY_W-1];
   assign link_off   = rd_data_ff[PFN_W-1:0] - pool_base_ff;
   assign stale      = link_off >= PFN_W'(POOL_FRAMES);
   assign pool_full  = next_free_ff == NF_W'(POOL_FRAMES);
   assign step_ok    = rd_present ? !stale : !pool_full;
   assign alloc_go   = ctrl.eval && !rd_present && !pool_full;
   assign alloc_pfn  = pool_base_ff + PFN_W'(next_free_ff);
   assign leaf_pfn   = pool_base_ff + PFN_W'(frame_ff);

   assign mem_addr  = ctrl.clear_wr ? clr_addr_ff : {frame_ff, walk_idx};
   assign mem_we    = ctrl.clear_wr || alloc_go;
   assign mem_wdata = ctrl.clear_wr ? '0 : {1'b1, alloc_pfn};

   assign accept        = ctrl.take_in && req_ch.valid;
   assign req_ch.ready  = ctrl.take_in;
   assign out_busy      = rsp_valid_ff && !rsp_ch.ready;
   assign out_load      = ctrl.emit && !out_busy;
   assign rsp_valid_in  = out_load || out_busy;

   always_comb begin
      stat.clear_more = clr_addr_ff != '1;
      stat.in_valid   = req_ch.valid;
      stat.walk_more  = step_ok && (level_ff != LVL_PD);
      stat.out_busy   = out_busy;
   end

   always_comb begin
      vpn_in       = vpn_ff;
      frame_in     = frame_ff;
      level_in     = level_ff;
      made_in      = made_ff;
      fail_in      = fail_ff;
      next_free_in = next_free_ff;
      clr_addr_in  = ctrl.clear_wr ? clr_addr_ff + 1'b1 : clr_addr_ff;
      if (accept) begin
         vpn_in   = req_ch.vaddr[VA_W-1 -: VPN_W];
         frame_in = '0;
         level_in = LVL_PML4;
         made_in  = '0;
         fail_in  = 1'b0;
      end else if (ctrl.eval) begin
         if (step_ok) begin
            level_in = level_ff + 1'b1;
            if (rd_present) begin
               frame_in = link_off[FRAME_W-1:0];
            end else begin
               frame_in     = next_free_ff[FRAME_W-1:0];
               made_in      = made_ff + 1'b1;
               next_free_in = next_free_ff + 1'b1;
            end
         end else begin
            fail_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         next_free_ff <= NF_W'(1);
         clr_addr_ff  <= '0;
         level_ff     <= LVL_PML4;
         made_ff      <= '0;
         fail_ff      <= 1'b0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pool_base_ff <= csr_wr_data[PA_W-1:PAGE_SHIFT];
         end
         next_free_ff <= next_free_in;
         clr_addr_ff  <= clr_addr_in;
         level_ff     <= level_in;
         made_ff      <= made_in;
         fail_ff      <= fail_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vpn_ff <= vpn_in;
      if (out_load) begin
         rsp_pte_ff    <= fail_ff ? '0 : {leaf_pfn, vpn_ff[IDX_W-1:0], PTE_SHIFT'(0)};
         rsp_status_ff <= fail_ff;
         rsp_made_ff   <= made_ff;
      end
   end

   // table store: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      if (ctrl.mem_rd) begin
         rd_data_ff <= table_mem[mem_addr];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pte_address    = rsp_pte_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.tables_created = rsp_made_ff;

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_pte_ff == '0)
      else $error("failed walk returned a nonzero entry address");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(POOL_FRAMES) && next_free_ff != '0)
      else $error("bump allocator out of range");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      alloc_go |=> next_free_ff == $past(next_free_ff) + 1'b1 && made_ff == $past(made_ff) + 1'b1)
      else $error("allocation did not advance allocator and count");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      ctrl.mem_rd |-> !mem_we)
      else $error("table read and write in the same cycle");

endmodule

// ===== tb/tb_page_table_walk_allocate_core.sv =====
`timescale 1ns / 100ps

module tb_page_table_walk_allocate_core import ptwa_pkg::*; ();

   localparam int QUIET_LIMIT     = 40000;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 12;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int HISTORY_DEPTH   = 64;
   localparam int MAX_PRINTED     = 100;
   localparam int PD_LSB          = PAGE_SHIFT + IDX_W;
   localparam int PDPT_LSB        = PD_LSB + IDX_W;
   localparam int PML4_LSB        = PDPT_LSB + IDX_W;

   localparam logic [63:0] ENTRY_PRESENT  = 64'h1;
   localparam logic [63:0] ENTRY_WRITABLE = 64'h2;

   // allocation order, partial allocation before running out, failure at each level
   localparam int FIRST_COUNT = 12;
   localparam logic [VA_W-1:0] FIRST_WALKS [FIRST_COUNT] = '{
      48'h0000_0000_0000, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_1000,
      48'h0000_0020_0000, 48'h0000_4000_0000, 48'h0080_0000_0000, 48'h0000_8000_0000,
      48'h0100_0000_0000, 48'h0200_0000_0000, 48'h0000_0040_0000, 48'h0100_0000_0000
   };
   // pool at the top of the space: links shift by one frame, sums wrap
   localparam int WRAP_COUNT = 4;
   localparam logic [VA_W-1:0] WRAP_WALKS [WRAP_COUNT] = '{
      48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0100_0000_0000, 48'h0000_8000_1FF8
   };

   typedef struct packed {
      logic [PA_W-1:0]   pte_address;
      logic              status;
      logic [MADE_W-1:0] tables_created;
   } walk_result_type;

   typedef enum int {
      PACE_FULL,
      PACE_SLOW_SEND,
      PACE_SLOW_RECV,
      PACE_BOTH
   } pace_type;

   class walk_scoreboard;
      logic [63:0]     table_copy [TABLE_ENTRIES];
      int unsigned     alloc_next;
      logic [PA_W-1:0] base_addr;
      walk_result_type expected_q [$];
      int unsigned     error_count;

      function new();
         foreach (table_copy[i]) table_copy[i] = '0;
         alloc_next  = 1;
         base_addr   = '0;
         error_count = 0;
      endfunction

      function void set_base(logic [PA_W-1:0] value);
         base_addr = {value[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      endfunction

      function logic [PA_W-1:0] frame_addr(int unsigned frame);
         return base_addr + (PA_W'(frame) << PAGE_SHIFT);
      endfunction

      // walk the table copy, allocating as the block does; return 1 when the walk completes
      function bit note_walk(logic [VA_W-1:0] va);
         int unsigned     frame;
         int unsigned     made;
         int unsigned     slot;
         int unsigned     lvl;
         logic [IDX_W-1:0] idx;
         logic [63:0]     entry;
         logic [PA_W-1:0] offset;
         logic [PA_W-1:0] link;
         bit              ok;
         walk_result_type res;
         frame = 0;
         made  = 0;
         ok    = 1'b1;
         for (lvl = 0; lvl < 3 && ok; lvl++) begin
            idx   = va[VA_W-1-IDX_W*lvl -: IDX_W];
            slot  = frame * ENTRIES_PER_TABLE + int'(idx);
            entry = table_copy[slot];
            if (entry[0]) begin
               // map the link back into the pool under the current base
               offset = {entry[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} - base_addr;
               if (offset[PA_W-1:PAGE_SHIFT] >= PFN_W'(POOL_FRAMES)) begin
                  ok = 1'b0;
               end else begin
                  frame = int'(offset[PAGE_SHIFT +: FRAME_W]);
               end
            end else if (alloc_next >= POOL_FRAMES) begin
               ok = 1'b0;
            end else begin
               link = frame_addr(alloc_next);
               table_copy[slot] = {{(64-PA_W){1'b0}}, link[PA_W-1:PAGE_SHIFT],
                                   {PAGE_SHIFT{1'b0}}} | ENTRY_WRITABLE | ENTRY_PRESENT;
               frame = alloc_next;
               alloc_next++;
               made++;
            end
         end
         if (ok) begin
            res.pte_address = frame_addr(frame)
                              + PA_W'({va[PAGE_SHIFT +: IDX_W], {PTE_SHIFT{1'b0}}});
         end else begin
            res.pte_address = '0;
         end
         res.status         = !ok;
         res.tables_created = MADE_W'(made);
         expected_q.push_back(res);
         return ok;
      endfunction

      task report(string what, logic [PA_W-1:0] got, logic [PA_W-1:0] want);
         if (error_count < MAX_PRINTED) begin
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
         end
         error_count++;
      endtask

      task check_result(walk_result_type got);
         walk_result_type want;
         if (expected_q.size() == 0) begin
            report("result with no walk pending", got.pte_address, '0);
            return;
         end
         want = expected_q.pop_front();
         if (got.pte_address !== want.pte_address) begin
            report("pte_address", got.pte_address, want.pte_address);
         end
         if (got.status !== want.status) begin
            report("status", PA_W'(got.status), PA_W'(want.status));
         end
         if (got.tables_created !== want.tables_created) begin
            report("tables_created", PA_W'(got.tables_created), PA_W'(want.tables_created));
         end
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   logic [PA_W-1:0] csr_wr_data;

   ptwa_req_if req_ch ();
   ptwa_rsp_if rsp_ch ();

   walk_scoreboard  board = new();
   logic [VA_W-1:0] good_va_q [$];
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   bit              hold_trigger   = 1'b0;
   int unsigned     quiet_cycles   = 0;

   page_table_walk_allocate_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_walk(input logic [VA_W-1:0] va);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vaddr <= va;
      do @(posedge clock); while (!req_ch.ready);
      if (board.note_walk(va)) begin
         good_va_q.push_back(va);
         if (good_va_q.size() > HISTORY_DEPTH) void'(good_va_q.pop_front());
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_pool_base(input logic [PA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.set_base(value);
   endtask

   initial begin
      int              p;
      int              n;
      int unsigned     roll;
      logic [VA_W-1:0] va;
      logic [VA_W-1:0] known;
      pace_type        pace;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_ch.valid = 1'b0;
      req_ch.vaddr = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_pool_base('0);
      for (n = 0; n < FIRST_COUNT; n++) send_walk(FIRST_WALKS[n]);
      wait_drained();
      write_pool_base('1);
      for (n = 0; n < WRAP_COUNT; n++) send_walk(WRAP_WALKS[n]);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         case (p)
            0, 4, 7: write_pool_base('0);
            1:       write_pool_base('1);
            2:       write_pool_base(PA_W'(3) << PAGE_SHIFT);
            5:       write_pool_base({PA_W{1'b1}} << (PAGE_SHIFT + 1));
            default: write_pool_base(PA_W'({$urandom, $urandom}));
         endcase
         pace = pace_type'(p % 4);
         case (pace)
            PACE_FULL:      begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SLOW_SEND: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            PACE_SLOW_RECV: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            PACE_BOTH:      begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         // back up the block while the sender keeps offering
         if (p == 4) hold_trigger = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            va   = VA_W'({$urandom, $urandom});
            // mostly revisit a walked path so that lookups hit existing links
            if (good_va_q.size() != 0 && roll >= 15) begin
               known = good_va_q[$urandom_range(good_va_q.size() - 1)];
               if (roll < 60) begin
                  va[VA_W-1:PD_LSB] = known[VA_W-1:PD_LSB];
               end else if (roll < 85) begin
                  va[VA_W-1:PDPT_LSB] = known[VA_W-1:PDPT_LSB];
               end else begin
                  va[VA_W-1:PML4_LSB] = known[VA_W-1:PML4_LSB];
               end
            end
            send_walk(va);
         end
      end

      wait_drained();
      if (board.error_count == 0) begin
         $display("page_table_walk_allocate_core test passed");
      end else begin
         $display("page_table_walk_allocate_core test failed");
      end
      $finish;
   end

   initial begin
      int unsigned hold_left;
      bit          hold_seen;
      hold_left    = 0;
      hold_seen    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result('{pte_address:    rsp_ch.pte_address,
                              status:         rsp_ch.status,
                              tables_created: rsp_ch.tables_created});
      end
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("page_table_walk_allocate_core test failed");
      $finish;
   end

endmodule
